@@ rtl/bafs_pkg.sv @@
// ============================================================================
// bafs_pkg
// Shared types and constants for the bit-addressable field store.
// ============================================================================
package bafs_pkg;

    // Fixed widths of the item fields.
    localparam int OPC_BITS  = 3;
    localparam int IDX_BITS  = 15;
    localparam int DATA_BITS = 32;
    localparam int LEN_BITS  = 6;

    // Default sizes of the store and of a word field.
    localparam int STORE_WORD_BITS_DEF = 32;
    localparam int STORE_WORDS_DEF     = 1024;
    localparam int FIELD_BITS_DEF      = 32;

    // Fraction bits of the reciprocal used to split a bit index into a word
    // index and an offset: index bits plus the bits of the widest word size.
    localparam int DIV_SHIFT = IDX_BITS + 7;

    // Entries of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OPC_BITS-1:0] {
        OP_GET_BIT    = 3'd0,
        OP_SET_BIT    = 3'd1,
        OP_WRITE_WORD = 3'd2,
        OP_READ_WORD  = 3'd3,
        OP_WRITE_LSB  = 3'd4
    } t_opcode;

    // What the back end has to do with a command.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  word_read;
        logic  err;
    } t_ctrl;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_RUN   = 2'd2
    } t_back_state;

endpackage

@@ rtl/bafs_if.sv @@
// ============================================================================
// bafs_if
// Valid/ready channels for request items and result items.
// ============================================================================
interface bafs_in_if import bafs_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [OPC_BITS-1:0]  opcode;
    logic [IDX_BITS-1:0]  bit_index;
    logic                 bit_value;
    logic [DATA_BITS-1:0] data;
    logic [LEN_BITS-1:0]  field_length;

    modport source (
        output valid, opcode, bit_index, bit_value, data, field_length,
        input  ready
    );
    modport sink (
        input  valid, opcode, bit_index, bit_value, data, field_length,
        output ready
    );
endinterface

interface bafs_out_if import bafs_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 read_bit;
    logic [DATA_BITS-1:0] read_word;
    logic                 range_error;

    modport source (
        output valid, read_bit, read_word, range_error,
        input  ready
    );
    modport sink (
        input  valid, read_bit, read_word, range_error,
        output ready
    );
endinterface

@@ rtl/bafs_ram.sv @@
// ============================================================================
// bafs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module bafs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bafs_queue.sv @@
// ============================================================================
// bafs_queue
// Short first-in first-out queue of classified commands.
// ============================================================================
module bafs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] ptr);
        logic [PW-1:0] nxt;
        if (ptr == PW'(DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + 1'b1;
        end
        return nxt;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

@@ rtl/bafs_front.sv @@
// ============================================================================
// bafs_front
// Accepts request items, splits the bit index into word and offset, checks
// the range and builds the field image and mask for the back end.
// ============================================================================
module bafs_front import bafs_pkg::*; #(
    parameter int STORE_WORD_BITS = STORE_WORD_BITS_DEF,
    parameter int STORE_WORDS     = STORE_WORDS_DEF,
    parameter int FIELD_BITS      = FIELD_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    bafs_in_if.sink                                       i_item,
    input  logic                                          i_clearing,
    input  logic                                          i_q_full,
    output logic                                          o_q_push,
    output t_ctrl                                         o_ctrl,
    output logic [$clog2(STORE_WORDS)-1:0]                o_word,
    output logic [$clog2(STORE_WORD_BITS)-1:0]            o_off,
    output logic [$clog2(STORE_WORD_BITS+FIELD_BITS)-1:0] o_rem,
    output logic [FIELD_BITS-1:0]                         o_g,
    output logic [FIELD_BITS-1:0]                         o_m
);

    localparam int AW   = $clog2(STORE_WORDS);
    localparam int OW   = $clog2(STORE_WORD_BITS);
    localparam int RW   = $clog2(STORE_WORD_BITS + FIELD_BITS);
    localparam int NW   = $clog2(FIELD_BITS + 1);
    localparam int PW   = IDX_BITS + DIV_SHIFT;
    localparam int SUMW = IDX_BITS + 1;
    localparam logic [PW-1:0] RECIP = PW'((64'd1 << DIV_SHIFT) / STORE_WORD_BITS);
    localparam longint unsigned TOTAL = longint'(STORE_WORDS) * longint'(STORE_WORD_BITS);
    localparam logic [SUMW-1:0] LIM = (TOTAL >= (64'd1 << SUMW)) ? '1 : SUMW'(TOTAL);

    // First stage: the accepted item and the reciprocal product.
    logic                 r_s1_valid;
    logic [OPC_BITS-1:0]  r_s1_op;
    logic [IDX_BITS-1:0]  r_s1_idx;
    logic                 r_s1_bval;
    logic [DATA_BITS-1:0] r_s1_data;
    logic [LEN_BITS-1:0]  r_s1_len;
    logic [PW-1:0]        r_s1_prod;

    logic                  w_accept;
    logic [PW-1:0]         w_prod;
    logic [IDX_BITS-1:0]   w_q0;
    logic [IDX_BITS-1:0]   w_r0;
    logic                  w_ge;
    logic [IDX_BITS-1:0]   w_q;
    logic [IDX_BITS-1:0]   w_r;
    logic [NW-1:0]         w_n;
    logic [SUMW-1:0]       w_sum;
    logic                  w_fits;
    logic [FIELD_BITS-1:0] w_data_fb;
    logic [FIELD_BITS-1:0] w_rev;
    t_ctrl                 w_ctrl;
    logic [FIELD_BITS-1:0] w_g;

    assign o_q_push     = r_s1_valid && !i_q_full;
    assign i_item.ready = !i_clearing && (!r_s1_valid || o_q_push);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_prod       = PW'(i_item.bit_index) * RECIP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (o_q_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op   <= i_item.opcode;
            r_s1_idx  <= i_item.bit_index;
            r_s1_bval <= i_item.bit_value;
            r_s1_data <= i_item.data;
            r_s1_len  <= i_item.field_length;
            r_s1_prod <= w_prod;
        end
    end

    // The estimated quotient is exact or one low; one compare fixes it.
    assign w_q0 = r_s1_prod[PW-1 -: IDX_BITS];
    assign w_r0 = r_s1_idx - IDX_BITS'(w_q0 * STORE_WORD_BITS);
    assign w_ge = (w_r0 >= IDX_BITS'(STORE_WORD_BITS));
    assign w_q  = w_ge ? w_q0 + 1'b1 : w_q0;
    assign w_r  = w_ge ? w_r0 - IDX_BITS'(STORE_WORD_BITS) : w_r0;

    assign w_data_fb = FIELD_BITS'(r_s1_data);

    always_comb begin
        for (int i = 0; i < FIELD_BITS; i++) begin
            w_rev[FIELD_BITS-1-i] = w_data_fb[i];
        end
    end

    always_comb begin
        w_n  = '0;
        w_g  = '0;
        w_ctrl.kind      = KIND_NONE;
        w_ctrl.word_read = 1'b0;
        case (r_s1_op)
            OP_GET_BIT: begin
                w_n         = NW'(1);
                w_ctrl.kind = KIND_READ;
            end
            OP_SET_BIT: begin
                w_n         = NW'(1);
                w_g         = FIELD_BITS'(r_s1_bval) << (FIELD_BITS - 1);
                w_ctrl.kind = KIND_WRITE;
            end
            OP_WRITE_WORD: begin
                w_n         = NW'(FIELD_BITS);
                w_g         = w_data_fb;
                w_ctrl.kind = KIND_WRITE;
            end
            OP_READ_WORD: begin
                w_n              = NW'(FIELD_BITS);
                w_ctrl.kind      = KIND_READ;
                w_ctrl.word_read = 1'b1;
            end
            OP_WRITE_LSB: begin
                if (r_s1_len > FIELD_BITS) begin
                    w_n = NW'(FIELD_BITS);
                end else begin
                    w_n = NW'(r_s1_len);
                end
                w_g         = w_rev;
                w_ctrl.kind = KIND_WRITE;
            end
            default: begin
                w_n         = '0;
                w_ctrl.kind = KIND_NONE;
            end
        endcase

        w_sum      = SUMW'(r_s1_idx) + SUMW'(w_n);
        w_fits     = (w_sum <= LIM);
        w_ctrl.err = (w_ctrl.kind != KIND_NONE) && !w_fits;
        // Out of range accesses and empty fields touch no storage word.
        if (!w_fits || w_n == '0) begin
            w_ctrl.kind = KIND_NONE;
        end
    end

    assign o_ctrl = w_ctrl;
    assign o_word = AW'(w_q);
    assign o_off  = OW'(w_r);
    assign o_rem  = RW'(w_r) + RW'(w_n);
    assign o_g    = w_g;
    assign o_m    = ~({FIELD_BITS{1'b1}} >> w_n);

endmodule

@@ rtl/bafs_back.sv @@
// ============================================================================
// bafs_back
// Clears the store after reset, then carries out commands word by word as
// masked read-modify-writes or gathered reads, and holds the result item.
// ============================================================================
module bafs_back import bafs_pkg::*; #(
    parameter int STORE_WORD_BITS = STORE_WORD_BITS_DEF,
    parameter int STORE_WORDS     = STORE_WORDS_DEF,
    parameter int FIELD_BITS      = FIELD_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_q_valid,
    output logic                                          o_q_pop,
    input  t_ctrl                                         i_ctrl,
    input  logic [$clog2(STORE_WORDS)-1:0]                i_word,
    input  logic [$clog2(STORE_WORD_BITS)-1:0]            i_off,
    input  logic [$clog2(STORE_WORD_BITS+FIELD_BITS)-1:0] i_rem,
    input  logic [FIELD_BITS-1:0]                         i_g,
    input  logic [FIELD_BITS-1:0]                         i_m,
    output logic                                          o_clearing,
    bafs_out_if.source                                    o_result
);

    localparam int SWB = STORE_WORD_BITS;
    localparam int AW  = $clog2(STORE_WORDS);
    localparam int OW  = $clog2(SWB);
    localparam int RW  = $clog2(SWB + FIELD_BITS);
    localparam int K   = (FIELD_BITS + 2 * SWB - 2) / SWB;
    localparam int KW  = $clog2(K);
    localparam int VW  = K * SWB;

    t_back_state r_state, n_state;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    t_ctrl                r_ctrl, n_ctrl;
    logic [AW-1:0]        r_addr, n_addr;
    logic [KW-1:0]        r_k, n_k;
    logic [RW-1:0]        r_rem, n_rem;
    logic [OW-1:0]        r_off, n_off;
    logic [VW-1:0]        r_v, n_v;
    logic [VW-1:0]        r_m, n_m;
    logic [VW-1:0]        r_r, n_r;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_bit, n_out_bit;
    logic [DATA_BITS-1:0] r_out_word, n_out_word;
    logic                 r_out_err, n_out_err;

    logic           w_out_free;
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [SWB-1:0] w_wdata;
    logic           w_re;
    logic [AW-1:0]  w_raddr;
    logic [SWB-1:0] w_rdata;
    logic [SWB-1:0] w_vk;
    logic [SWB-1:0] w_mk;
    logic [VW-1:0]  w_aligned;

    bafs_ram #(
        .WIDTH (SWB),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctrl     <= n_ctrl;
        r_addr     <= n_addr;
        r_k        <= n_k;
        r_rem      <= n_rem;
        r_off      <= n_off;
        r_v        <= n_v;
        r_m        <= n_m;
        r_r        <= n_r;
        r_out_bit  <= n_out_bit;
        r_out_word <= n_out_word;
        r_out_err  <= n_out_err;
    end

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_vk       = r_v[VW-1 -: SWB];
    assign w_mk       = r_m[VW-1 -: SWB];

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_ctrl      = r_ctrl;
        n_addr      = r_addr;
        n_k         = r_k;
        n_rem       = r_rem;
        n_off       = r_off;
        n_v         = r_v;
        n_m         = r_m;
        n_r         = r_r;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_bit   = r_out_bit;
        n_out_word  = r_out_word;
        n_out_err   = r_out_err;
        o_q_pop     = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_addr;
        w_wdata     = (w_rdata & ~w_mk) | (w_vk & w_mk);
        w_re        = 1'b0;
        w_raddr     = r_addr;
        w_aligned   = '0;

        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
                if (r_clr_addr == AW'(STORE_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_q_valid && w_out_free) begin
                    o_q_pop = 1'b1;
                    n_ctrl  = i_ctrl;
                    n_addr  = i_word;
                    n_k     = '0;
                    n_rem   = i_rem;
                    n_off   = i_off;
                    n_v     = {i_g, {(VW - FIELD_BITS){1'b0}}} >> i_off;
                    n_m     = {i_m, {(VW - FIELD_BITS){1'b0}}} >> i_off;
                    if (i_ctrl.kind == KIND_NONE) begin
                        n_out_valid = 1'b1;
                        n_out_bit   = 1'b0;
                        n_out_word  = '0;
                        n_out_err   = i_ctrl.err;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = i_word;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                // Read data of the current word is here: a write merges and writes it
                // back, and it is kept in its slot of the gather window.
                w_we = (r_ctrl.kind == KIND_WRITE);
                for (int j = 0; j < K; j++) begin
                    if (r_k == KW'(j)) begin
                        n_r[VW-1-j*SWB -: SWB] = w_rdata;
                    end
                end
                w_aligned = n_r << r_off;
                if (r_rem <= RW'(SWB)) begin
                    n_out_valid = 1'b1;
                    n_out_err   = 1'b0;
                    n_out_bit   = (r_ctrl.kind == KIND_READ) && !r_ctrl.word_read
                                  && w_aligned[VW-1];
                    if ((r_ctrl.kind == KIND_READ) && r_ctrl.word_read) begin
                        n_out_word = DATA_BITS'(w_aligned[VW-1 -: FIELD_BITS]);
                    end else begin
                        n_out_word = '0;
                    end
                    n_state = ST_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_addr + 1'b1;
                    n_addr  = r_addr + 1'b1;
                    n_k     = r_k + 1'b1;
                    n_rem   = r_rem - RW'(SWB);
                    n_v     = r_v << SWB;
                    n_m     = r_m << SWB;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_clearing         = (r_state == ST_CLEAR);
    assign o_result.valid     = r_out_valid;
    assign o_result.read_bit  = r_out_bit;
    assign o_result.read_word = r_out_word;
    assign o_result.range_error = r_out_err;

endmodule

@@ rtl/bit_addressable_field_store.sv @@
// ============================================================================
// bit_addressable_field_store
// Bit-addressable store with single-bit, word and LSB-first field access.
// ============================================================================
// After reset the block runs a clearing pass that zeroes every word of the
// storage RAM; no item is accepted until it ends. An accepted item is held
// in the front end's stage register, where its bit index is split into a
// word address and an offset and its range is checked, then waits in a
// two-entry queue. The back end owns the single-read-port, registered-read
// RAM: it issues the first read when it takes an item, then handles one
// touched storage word per step, reading the next word while it keeps the
// current one and, for a write, merges it and writes it back. Items that
// fail the range check, carry an unknown opcode or write an empty field
// touch no word; the back end gives their result item as soon as it takes
// them. Writes are masked read-modify-writes of each touched word. A
// finished result item waits in an output register; the back end takes the
// next queued item only once that register is empty or is being read in
// the same cycle.
// ============================================================================
module bit_addressable_field_store import bafs_pkg::*; #(
    parameter int STORE_WORD_BITS = STORE_WORD_BITS_DEF,
    parameter int STORE_WORDS     = STORE_WORDS_DEF,
    parameter int FIELD_BITS      = FIELD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bafs_in_if.sink     i_item,
    bafs_out_if.source  o_result
);

    localparam int AW = $clog2(STORE_WORDS);
    localparam int OW = $clog2(STORE_WORD_BITS);
    localparam int RW = $clog2(STORE_WORD_BITS + FIELD_BITS);
    localparam int CW = $bits(t_ctrl);
    // Queue entry: control, word address, offset, bit span, field and mask.
    localparam int QW = CW + AW + OW + RW + 2 * FIELD_BITS;

    logic                  w_clearing;
    logic                  w_q_full;
    logic                  w_q_push;
    logic                  w_q_pop;
    logic                  w_q_valid;
    logic [QW-1:0]         w_q_in;
    logic [QW-1:0]         w_q_out;

    t_ctrl                 w_f_ctrl;
    logic [AW-1:0]         w_f_word;
    logic [OW-1:0]         w_f_off;
    logic [RW-1:0]         w_f_rem;
    logic [FIELD_BITS-1:0] w_f_g;
    logic [FIELD_BITS-1:0] w_f_m;

    t_ctrl                 w_b_ctrl;
    logic [AW-1:0]         w_b_word;
    logic [OW-1:0]         w_b_off;
    logic [RW-1:0]         w_b_rem;
    logic [FIELD_BITS-1:0] w_b_g;
    logic [FIELD_BITS-1:0] w_b_m;

    // The front end classifies each item and prepares its field image.
    bafs_front #(
        .STORE_WORD_BITS (STORE_WORD_BITS),
        .STORE_WORDS     (STORE_WORDS),
        .FIELD_BITS      (FIELD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_clearing (w_clearing),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_ctrl     (w_f_ctrl),
        .o_word     (w_f_word),
        .o_off      (w_f_off),
        .o_rem      (w_f_rem),
        .o_g        (w_f_g),
        .o_m        (w_f_m)
    );

    assign w_q_in = {w_f_ctrl, w_f_word, w_f_off, w_f_rem, w_f_g, w_f_m};

    // The queue lets the front keep accepting while the back end is busy
    // with a multi-word access.
    bafs_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    assign {w_b_ctrl, w_b_word, w_b_off, w_b_rem, w_b_g, w_b_m} = w_q_out;

    // The back end owns the storage RAM and the result register.
    bafs_back #(
        .STORE_WORD_BITS (STORE_WORD_BITS),
        .STORE_WORDS     (STORE_WORDS),
        .FIELD_BITS      (FIELD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .o_q_pop    (w_q_pop),
        .i_ctrl     (w_b_ctrl),
        .i_word     (w_b_word),
        .i_off      (w_b_off),
        .i_rem      (w_b_rem),
        .i_g        (w_b_g),
        .i_m        (w_b_m),
        .o_clearing (w_clearing),
        .o_result   (o_result)
    );

endmodule

@@ dv/bafs_tb_pkg.sv @@
// ============================================================================
// bafs_tb_pkg
// Scoreboard for the bit-addressable field store bench.
// ============================================================================
// A flat bit array mirrors the store: entry b is bit index b. Every accepted
// request item queues the result item it should give; write items also update the mirror.
// ============================================================================
package bafs_tb_pkg;
    import bafs_pkg::*;

    localparam int TOTAL_BITS   = STORE_WORDS_DEF * STORE_WORD_BITS_DEF;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic                 read_bit;
        logic [DATA_BITS-1:0] read_word;
        logic                 range_error;
    } t_result;

    class field_store_scoreboard;
        bit      mirror [TOTAL_BITS];
        t_result awaited [$];
        int      mismatches;
        int      results_checked;
        int      range_errors;
        int      op_seen [1 << OPC_BITS];

        // Applies one request item to the mirror and queues its result item.
        function void note_request(logic [OPC_BITS-1:0]  opcode,
                                   logic [IDX_BITS-1:0]  bit_index,
                                   logic                 bit_value,
                                   logic [DATA_BITS-1:0] data,
                                   logic [LEN_BITS-1:0]  field_length);
            t_result              want;
            logic [DATA_BITS-1:0] acc;
            int                   start;
            int                   len;
            int                   i;
            want  = '{1'b0, '0, 1'b0};
            acc   = '0;
            start = int'(bit_index);
            len   = (field_length > FIELD_BITS_DEF) ? FIELD_BITS_DEF : int'(field_length);
            op_seen[opcode]++;
            case (opcode)
                OP_GET_BIT: begin
                    if (start + 1 <= TOTAL_BITS) want.read_bit = mirror[start];
                    else want.range_error = 1'b1;
                end
                OP_SET_BIT: begin
                    if (start + 1 <= TOTAL_BITS) mirror[start] = bit_value;
                    else want.range_error = 1'b1;
                end
                OP_WRITE_WORD: begin
                    if (start + FIELD_BITS_DEF <= TOTAL_BITS) begin
                        for (i = 0; i < FIELD_BITS_DEF; i++)
                            mirror[start + i] = data[FIELD_BITS_DEF - 1 - i];
                    end else begin
                        want.range_error = 1'b1;
                    end
                end
                OP_READ_WORD: begin
                    if (start + FIELD_BITS_DEF <= TOTAL_BITS) begin
                        for (i = 0; i < FIELD_BITS_DEF; i++)
                            acc = {acc[DATA_BITS-2:0], mirror[start + i]};
                        want.read_word = acc;
                    end else begin
                        want.range_error = 1'b1;
                    end
                end
                OP_WRITE_LSB: begin
                    if (start + len <= TOTAL_BITS) begin
                        for (i = 0; i < len; i++)
                            mirror[start + i] = data[i];
                    end else begin
                        want.range_error = 1'b1;
                    end
                end
                default: ;
            endcase
            if (want.range_error) range_errors++;
            awaited.push_back(want);
        endfunction

        // Compares one accepted result item with the oldest one outstanding.
        function void check_result(logic read_bit, logic [DATA_BITS-1:0] read_word,
                                   logic range_error);
            t_result want;
            results_checked++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result item: bit %0b word %h range_error %0b",
                             read_bit, read_word, range_error);
                return;
            end
            want = awaited.pop_front();
            if (want.read_bit !== read_bit || want.read_word !== read_word ||
                want.range_error !== range_error) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("result item %0d differs: expected bit %0b word %h range_error %0b",
                             results_checked, want.read_bit, want.read_word,
                             want.range_error);
                    $display("    got bit %0b word %h range_error %0b",
                             read_bit, read_word, range_error);
                end
            end
        endfunction
    endclass

endpackage

@@ dv/bit_addressable_field_store_tb.sv @@
// ============================================================================
// bit_addressable_field_store_tb
// Self-checking bench for the bit-addressable field store.
// ============================================================================
// A directed opening hits both ends of the store, straddling word accesses,
// the last legal and first illegal starts, empty and oversized fields and the first
// and last unused opcodes. Random request items follow, aimed mostly at small
// windows and recently written indices so reads return data written earlier. Both
// handshakes idle at random, and the result side holds off once for a long
// stretch to back the block up.
// ============================================================================
module bit_addressable_field_store_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bafs_pkg::*;
    import bafs_tb_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int MAX_GAP       = 16;
    localparam int PACE_SPAN     = 40;
    localparam int WINDOW_SPAN   = 100;
    localparam int HOLD_AFTER    = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 16;
    // The limit must cover the clearing pass, during which nothing is accepted.
    localparam int STALL_LIMIT   = 4 * STORE_WORDS_DEF;
    localparam int LAST_BIT      = TOTAL_BITS - 1;
    localparam int LAST_WORD_AT  = TOTAL_BITS - FIELD_BITS_DEF;
    localparam logic [OPC_BITS-1:0] OPC_FIRST_UNKNOWN = OPC_BITS'(int'(OP_WRITE_LSB) + 1);
    localparam logic [OPC_BITS-1:0] OPC_LAST          = '1;
    localparam logic [IDX_BITS-1:0] IDX_LAST_BIT      = IDX_BITS'(LAST_BIT);
    localparam logic [IDX_BITS-1:0] IDX_LAST_WORD     = IDX_BITS'(LAST_WORD_AT);
    localparam logic [IDX_BITS-1:0] IDX_PAST_WORD     = IDX_BITS'(LAST_WORD_AT + 1);
    localparam logic [IDX_BITS-1:0] IDX_PAST_FIELD    = IDX_BITS'(LAST_WORD_AT + 4);
    localparam logic [LEN_BITS-1:0] LEN_FULL          = LEN_BITS'(FIELD_BITS_DEF);

    // How a side spaces its handshakes over a stretch of items.
    typedef enum int {
        PACE_FLAT_OUT,
        PACE_RANDOM,
        PACE_BURSTY
    } t_pace;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bafs_in_if  in_ch ();
    bafs_out_if out_ch ();

    bit_addressable_field_store i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch)
    );

    field_store_scoreboard store_check = new();

    t_pace               send_pace   = PACE_RANDOM;
    t_pace               recv_pace   = PACE_RANDOM;
    int                  sent_items  = 0;
    int                  recv_items  = 0;
    int                  idle_cycles = 0;
    logic [IDX_BITS-1:0] last_index  = '0;
    logic [IDX_BITS-1:0] window_base = '0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic t_pace draw_pace();
        return t_pace'($urandom_range(0, int'(PACE_BURSTY)));
    endfunction

    // Flat-out stretches never idle, bursty ones idle about one item in four.
    function automatic int draw_gap(t_pace pace);
        case (pace)
            PACE_FLAT_OUT: return 0;
            PACE_RANDOM:   return $urandom_range(0, MAX_GAP);
            default:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
        endcase
    endfunction

    // Offers one request item and returns once it has been accepted. When the
    // drawn gap is zero, valid simply stays high into the next item, so it
    // never gets two assignments in one time step.
    task automatic send_request(input logic [OPC_BITS-1:0]  opcode,
                                input logic [IDX_BITS-1:0]  bit_index,
                                input logic                 bit_value,
                                input logic [DATA_BITS-1:0] data,
                                input logic [LEN_BITS-1:0]  field_length);
        int gap;
        if (sent_items % PACE_SPAN == 0) send_pace = draw_pace();
        gap = draw_gap(send_pace);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= opcode;
        in_ch.bit_index    <= bit_index;
        in_ch.bit_value    <= bit_value;
        in_ch.data         <= data;
        in_ch.field_length <= field_length;
        // Sampled right at the edge, so ready is its value before the edge.
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        store_check.note_request(opcode, bit_index, bit_value, data, field_length);
        sent_items++;
    endtask

    // Builds one random request item. Most indices fall near the previous one
    // or inside a moving window, so reads land on bits written shortly before;
    // a tenth sit at the top of the store to hit the range check.
    task automatic random_request();
        logic [OPC_BITS-1:0] opcode;
        logic [IDX_BITS-1:0] idx;
        logic [LEN_BITS-1:0] len;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 19)      opcode = OP_GET_BIT;
        else if (pick < 38) opcode = OP_SET_BIT;
        else if (pick < 57) opcode = OP_WRITE_WORD;
        else if (pick < 76) opcode = OP_READ_WORD;
        else if (pick < 95) opcode = OP_WRITE_LSB;
        else opcode = OPC_BITS'($urandom_range(int'(OPC_FIRST_UNKNOWN), int'(OPC_LAST)));

        pick = $urandom_range(0, 99);
        if (pick < 30)
            idx = IDX_BITS'(int'(last_index) + int'($urandom_range(0, 40)) - 20);
        else if (pick < 65)
            idx = IDX_BITS'(int'(window_base) + int'($urandom_range(0, 255)));
        else if (pick < 75)
            idx = IDX_BITS'($urandom_range(LAST_WORD_AT - 40, LAST_BIT));
        else
            idx = IDX_BITS'($urandom_range(0, LAST_BIT));

        // Lengths above the word size are saturated by the block.
        if ($urandom_range(0, 4) != 0)
            len = LEN_BITS'($urandom_range(0, FIELD_BITS_DEF));
        else
            len = LEN_BITS'($urandom_range(FIELD_BITS_DEF + 1, (1 << LEN_BITS) - 1));

        last_index = idx;
        send_request(opcode, idx, 1'($urandom_range(0, 1)), $urandom(), len);
    endtask

    // Result side. It waits a drawn number of cycles before each item, except
    // once, after HOLD_AFTER items, when it holds ready low for HOLD_CYCLES so
    // the queue and the output register fill and the input side stalls.
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (recv_items % PACE_SPAN == 0) recv_pace = draw_pace();
            gap = (recv_items == HOLD_AFTER) ? HOLD_CYCLES : draw_gap(recv_pace);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            store_check.check_result(out_ch.read_bit, out_ch.read_word, out_ch.range_error);
            recv_items++;
        end
    end

    // Watchdog: ends the run when neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no item moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int unknown_ops;
        in_ch.valid        <= 1'b0;
        in_ch.opcode       <= OP_GET_BIT;
        in_ch.bit_index    <= '0;
        in_ch.bit_value    <= 1'b0;
        in_ch.data         <= '0;
        in_ch.field_length <= '0;
        i_rst_n            <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Both ends of the store read back zero after the clearing pass, then
        // take single bits.
        send_request(OP_GET_BIT, '0, 1'b0, '0, '0);
        send_request(OP_GET_BIT, IDX_LAST_BIT, 1'b0, '0, '0);
        send_request(OP_SET_BIT, '0, 1'b1, '0, '0);
        send_request(OP_SET_BIT, IDX_LAST_BIT, 1'b1, '0, '0);
        send_request(OP_GET_BIT, '0, 1'b0, '0, '0);
        send_request(OP_GET_BIT, IDX_LAST_BIT, 1'b0, '0, '0);
        send_request(OP_SET_BIT, '0, 1'b0, '0, '0);

        // Word writes: aligned, straddling two storage words, the last start
        // that fits and the first one that runs past the end.
        send_request(OP_WRITE_WORD, '0, 1'b0, 32'hFFFF_FFFF, '0);
        send_request(OP_WRITE_WORD, 15'd17, 1'b0, 32'hA5C3_0F96, '0);
        send_request(OP_WRITE_WORD, IDX_LAST_WORD, 1'b0, 32'h8000_0001, '0);
        send_request(OP_WRITE_WORD, IDX_PAST_WORD, 1'b0, 32'h5555_AAAA, '0);
        send_request(OP_READ_WORD, '0, 1'b0, '0, '0);
        send_request(OP_READ_WORD, 15'd17, 1'b0, '0, '0);
        send_request(OP_READ_WORD, IDX_LAST_WORD, 1'b0, '0, '0);
        send_request(OP_READ_WORD, IDX_PAST_WORD, 1'b0, '0, '0);
        send_request(OP_READ_WORD, IDX_LAST_BIT, 1'b0, '0, '0);

        // LSB-first fields: empty, full, saturated, one bit at the very end,
        // and two that overrun the end, one of them with a length that saturates.
        send_request(OP_WRITE_LSB, 15'd5, 1'b0, 32'hFFFF_FFFF, '0);
        send_request(OP_READ_WORD, '0, 1'b0, '0, '0);
        send_request(OP_WRITE_LSB, 15'd40, 1'b0, 32'h1234_5678, LEN_FULL);
        send_request(OP_WRITE_LSB, 15'd100, 1'b0, 32'hDEAD_BEEF, '1);
        send_request(OP_WRITE_LSB, IDX_LAST_BIT, 1'b0, 32'h0000_0000, 6'd1);
        send_request(OP_WRITE_LSB, IDX_LAST_BIT, 1'b0, 32'h0000_0003, 6'd2);
        send_request(OP_WRITE_LSB, IDX_PAST_FIELD, 1'b0, 32'hFFFF_FFFF, 6'd40);
        send_request(OP_READ_WORD, 15'd40, 1'b0, '0, '0);
        send_request(OP_READ_WORD, 15'd100, 1'b0, '0, '0);

        // Unused opcodes must leave the store alone and return all zeros.
        send_request(OPC_FIRST_UNKNOWN, '0, 1'b1, 32'hFFFF_FFFF, '1);
        send_request(OPC_LAST, IDX_LAST_BIT, 1'b1, 32'hFFFF_FFFF, '1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % WINDOW_SPAN == 0) window_base = IDX_BITS'($urandom_range(0, LAST_BIT));
            random_request();
        end
        in_ch.valid <= 1'b0;

        while (store_check.awaited.size() != 0) @(posedge i_clk);
        // A few more cycles so a stray extra result item would still be seen.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        unknown_ops = sent_items - store_check.op_seen[OP_GET_BIT]
                    - store_check.op_seen[OP_SET_BIT] - store_check.op_seen[OP_WRITE_WORD]
                    - store_check.op_seen[OP_READ_WORD] - store_check.op_seen[OP_WRITE_LSB];
        $write("sent %0d request items: %0d bit reads, %0d bit writes, ",
               sent_items, store_check.op_seen[OP_GET_BIT], store_check.op_seen[OP_SET_BIT]);
        $write("%0d word writes, %0d word reads, ",
               store_check.op_seen[OP_WRITE_WORD], store_check.op_seen[OP_READ_WORD]);
        $display("%0d field writes, %0d unused opcodes",
                 store_check.op_seen[OP_WRITE_LSB], unknown_ops);
        $write("checked %0d result items, %0d past the end, ",
               store_check.results_checked, store_check.range_errors);
        $display("one %0d-cycle result hold-off, %0d mismatches",
                 HOLD_CYCLES, store_check.mismatches);
        if (store_check.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
